>>> src/vsos_pkg.sv
// ----------------------------------------------------------------------------
// vsos_pkg
// Shared types, constants and helpers of the volume slice overlay scanner.
// ----------------------------------------------------------------------------
package vsos_pkg;

   localparam int MAX_DIM    = 512;
   localparam int MAX_MARKS  = 4;
   localparam int MARK_SLOTS = 4;
   localparam int MARK_LIMIT = (MAX_MARKS < MARK_SLOTS) ? MAX_MARKS : MARK_SLOTS;

   localparam int DIM_W   = 10;
   localparam int SLICE_W = 9;
   localparam int CNT_W   = 9;
   localparam int ADDR_W  = 27;
   localparam int PIX_W   = 18;
   localparam int AXIS_W  = 2;
   localparam int MCNT_W  = 3;
   localparam int COLOR_W = 24;
   localparam int CREG_W  = 48;
   localparam int DXY_W   = 2 * DIM_W;
   localparam int PROD_W  = SLICE_W + DXY_W;
   localparam int CSR_IDX_W = 3;

   localparam logic [AXIS_W-1:0] AXIS_X = AXIS_W'(0);
   localparam logic [AXIS_W-1:0] AXIS_Y = AXIS_W'(1);
   localparam logic [AXIS_W-1:0] AXIS_Z = AXIS_W'(2);

   localparam logic [CSR_IDX_W-1:0] REG_DIM_X       = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_DIM_Y       = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_DIM_Z       = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_AXIS        = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_SLICE       = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] REG_MARK_COUNT  = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] REG_MARK_COLS_A = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] REG_MARK_COLS_B = CSR_IDX_W'(7);

   localparam logic FUNC_RESTART = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_B,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic load_item;
      logic mul_a;
      logic mul_b;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic [DIM_W-1:0]                   dim_x;
      logic [DIM_W-1:0]                   dim_y;
      logic [DIM_W-1:0]                   dim_z;
      logic [AXIS_W-1:0]                  axis;
      logic [SLICE_W-1:0]                 slice;
      logic [MCNT_W-1:0]                  mark_n;
      logic [MARK_SLOTS-1:0][COLOR_W-1:0] colors;
   } cfg_type;

   // zero reads as one, oversize clamps to the maximum extent
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

>>> src/volume_slice_overlay_scanner_core.sv
// ----------------------------------------------------------------------------
// volume_slice_overlay_scanner_core
// Items pass from acceptance through the two multiply steps of the sequencer
// to the commit, which loads the output register and sets rsp_tvalid; the
// commit waits while the output register is held. The next item is taken
// after the commit, also while a result waits in the output register.
// Reset: synchronous, scan idle, extents 1, other CSR and scan state 0.
// ----------------------------------------------------------------------------
module volume_slice_overlay_scanner_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [15:0]                         req_tdata,  // voxel_value, mark_mask
   input  logic                                req_tuser,  // func
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // red, green, blue, pixel_number, fetch_address
   output logic [71:0]                         rsp_tdata,
   output logic                                rsp_tlast,  // last_pixel
   output logic                                rsp_tuser,  // slice_error
   input  logic                                csr_wr_en,
   input  logic [vsos_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [vsos_pkg::CREG_W-1:0]         csr_wdata
);

   vsos_pkg::cmd_type           cmd;
   vsos_pkg::cfg_type           cfg;
   logic [7:0]                  red, green, blue;
   logic [vsos_pkg::PIX_W-1:0]  pixel_number;
   logic [vsos_pkg::ADDR_W-1:0] fetch_address;

   vsos_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   vsos_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   vsos_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cfg       (cfg),
      .in_func   (req_tuser),
      .in_voxel  (req_tdata[7:0]),
      .in_mask   (req_tdata[11:8]),
      .out_red   (red),
      .out_green (green),
      .out_blue  (blue),
      .out_pixel (pixel_number),
      .out_fetch (fetch_address),
      .out_last  (rsp_tlast),
      .out_error (rsp_tuser)
   );

   assign rsp_tdata = {3'b000, fetch_address, pixel_number, blue, green, red};

endmodule

>>> src/vsos_csr.sv
// ----------------------------------------------------------------------------
// vsos_csr
// Configuration registers with effective extent and mark count decoding.
// ----------------------------------------------------------------------------
module vsos_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [vsos_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [vsos_pkg::CREG_W-1:0]           csr_wdata,
   output vsos_pkg::cfg_type                     cfg
);

   logic [vsos_pkg::DIM_W-1:0]   dim_x_ff, dim_y_ff, dim_z_ff;
   logic [vsos_pkg::AXIS_W-1:0]  axis_ff;
   logic [vsos_pkg::SLICE_W-1:0] slice_ff;
   logic [vsos_pkg::MCNT_W-1:0]  mcnt_ff;
   logic [vsos_pkg::CREG_W-1:0]  cols_a_ff, cols_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_x_ff  <= vsos_pkg::DIM_W'(1);
         dim_y_ff  <= vsos_pkg::DIM_W'(1);
         dim_z_ff  <= vsos_pkg::DIM_W'(1);
         axis_ff   <= '0;
         slice_ff  <= '0;
         mcnt_ff   <= '0;
         cols_a_ff <= '0;
         cols_b_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            vsos_pkg::REG_DIM_X:       dim_x_ff  <= csr_wdata[vsos_pkg::DIM_W-1:0];
            vsos_pkg::REG_DIM_Y:       dim_y_ff  <= csr_wdata[vsos_pkg::DIM_W-1:0];
            vsos_pkg::REG_DIM_Z:       dim_z_ff  <= csr_wdata[vsos_pkg::DIM_W-1:0];
            vsos_pkg::REG_AXIS:        axis_ff   <= csr_wdata[vsos_pkg::AXIS_W-1:0];
            vsos_pkg::REG_SLICE:       slice_ff  <= csr_wdata[vsos_pkg::SLICE_W-1:0];
            vsos_pkg::REG_MARK_COUNT:  mcnt_ff   <= csr_wdata[vsos_pkg::MCNT_W-1:0];
            vsos_pkg::REG_MARK_COLS_A: cols_a_ff <= csr_wdata;
            vsos_pkg::REG_MARK_COLS_B: cols_b_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.dim_x  = vsos_pkg::eff_dim(dim_x_ff);
      cfg.dim_y  = vsos_pkg::eff_dim(dim_y_ff);
      cfg.dim_z  = vsos_pkg::eff_dim(dim_z_ff);
      cfg.axis   = axis_ff;
      cfg.slice  = slice_ff;
      cfg.mark_n = (mcnt_ff > vsos_pkg::MCNT_W'(vsos_pkg::MARK_LIMIT)) ?
                   vsos_pkg::MCNT_W'(vsos_pkg::MARK_LIMIT) : mcnt_ff;
      cfg.colors = {cols_b_ff, cols_a_ff};
   end

endmodule

>>> src/vsos_ctrl.sv
// ----------------------------------------------------------------------------
// vsos_ctrl
// Item sequencer: accept, two multiply steps, commit into the output register.
// ----------------------------------------------------------------------------
module vsos_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output vsos_pkg::cmd_type cmd
);

   vsos_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vsos_pkg::ST_IDLE:   if (req_tvalid) state_in = vsos_pkg::ST_MUL_A;
         vsos_pkg::ST_MUL_A:  state_in = vsos_pkg::ST_MUL_B;
         vsos_pkg::ST_MUL_B:  state_in = vsos_pkg::ST_COMMIT;
         vsos_pkg::ST_COMMIT: if (out_free) state_in = vsos_pkg::ST_IDLE;
         default:             state_in = vsos_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready    = (state_ff == vsos_pkg::ST_IDLE);
      cmd.load_item = req_tready && req_tvalid;
      cmd.mul_a     = (state_ff == vsos_pkg::ST_MUL_A);
      cmd.mul_b     = (state_ff == vsos_pkg::ST_MUL_B);
      cmd.commit    = (state_ff == vsos_pkg::ST_COMMIT) && out_free;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vsos_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> src/vsos_datapath.sv
// ----------------------------------------------------------------------------
// vsos_datapath
// Stride products, scan position state, overlay colour select, result register.
// ----------------------------------------------------------------------------
module vsos_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  vsos_pkg::cmd_type               cmd,
   input  vsos_pkg::cfg_type               cfg,
   input  logic                            in_func,
   input  logic [7:0]                      in_voxel,
   input  logic [vsos_pkg::MARK_SLOTS-1:0] in_mask,
   output logic [7:0]                      out_red,
   output logic [7:0]                      out_green,
   output logic [7:0]                      out_blue,
   output logic [vsos_pkg::PIX_W-1:0]      out_pixel,
   output logic [vsos_pkg::ADDR_W-1:0]     out_fetch,
   output logic                            out_last,
   output logic                            out_error
);

   localparam int DIM_W  = vsos_pkg::DIM_W;
   localparam int ADDR_W = vsos_pkg::ADDR_W;

   // item latch and products
   logic                            func_ff;
   logic [7:0]                      voxel_ff;
   logic [vsos_pkg::MARK_SLOTS-1:0] mask_ff;
   logic [vsos_pkg::DXY_W-1:0]      dxy_ff;
   logic [vsos_pkg::PROD_W-1:0]     prod_ff;

   // scan state
   logic [vsos_pkg::CNT_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [ADDR_W-1:0]          rsa_ff, rsa_in, cur_ff, cur_in;
   logic [vsos_pkg::PIX_W-1:0] pix_ff, pix_in;
   logic                       active_ff, active_in;

   // result register
   logic [7:0]                 red_ff, green_ff, blue_ff, red_in, green_in, blue_in;
   logic [vsos_pkg::PIX_W-1:0] opix_ff, opix_in;
   logic [ADDR_W-1:0]          fetch_ff, fetch_in;
   logic                       last_ff, last_in, err_ff, err_in;

   logic [DIM_W-1:0]  width, height, extent;
   logic [ADDR_W-1:0] col_stride, row_stride, start, row_next;
   logic              bad_axis;
   logic [DIM_W-1:0]  next_col, next_row;
   logic [23:0]       colour;

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         func_ff  <= in_func;
         voxel_ff <= in_voxel;
         mask_ff  <= in_mask;
      end
      if (cmd.mul_a) begin
         dxy_ff <= cfg.dim_x * cfg.dim_y;
      end
      if (cmd.mul_b) begin
         prod_ff <= cfg.slice * ((cfg.axis == vsos_pkg::AXIS_Y) ?
                    vsos_pkg::DXY_W'(cfg.dim_x) : dxy_ff);
      end
   end

   always_comb begin
      bad_axis = 1'b0;
      unique case (cfg.axis)
         vsos_pkg::AXIS_X: begin
            width      = cfg.dim_y;
            height     = cfg.dim_z;
            col_stride = ADDR_W'(cfg.dim_x);
            row_stride = ADDR_W'(dxy_ff);
            extent     = cfg.dim_x;
            start      = ADDR_W'(cfg.slice);
         end
         vsos_pkg::AXIS_Y: begin
            width      = cfg.dim_x;
            height     = cfg.dim_z;
            col_stride = ADDR_W'(1);
            row_stride = ADDR_W'(dxy_ff);
            extent     = cfg.dim_y;
            start      = prod_ff[ADDR_W-1:0];
         end
         default: begin
            width      = cfg.dim_x;
            height     = cfg.dim_y;
            col_stride = ADDR_W'(1);
            row_stride = ADDR_W'(cfg.dim_x);
            extent     = cfg.dim_z;
            start      = prod_ff[ADDR_W-1:0];
            bad_axis   = (cfg.axis != vsos_pkg::AXIS_Z);
         end
      endcase
   end

   // highest enabled hit mark wins
   always_comb begin
      colour = {voxel_ff, voxel_ff, voxel_ff};
      for (int i = 0; i < vsos_pkg::MARK_SLOTS; i++) begin
         if (mask_ff[i] && (vsos_pkg::MCNT_W'(i) < cfg.mark_n)) begin
            colour = cfg.colors[i];
         end
      end
   end

   assign next_col = DIM_W'(col_ff) + DIM_W'(1);
   assign next_row = DIM_W'(row_ff) + DIM_W'(1);
   assign row_next = rsa_ff + row_stride;

   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      rsa_in    = rsa_ff;
      cur_in    = cur_ff;
      pix_in    = pix_ff;
      active_in = active_ff;
      red_in    = '0;
      green_in  = '0;
      blue_in   = '0;
      opix_in   = '0;
      fetch_in  = '0;
      last_in   = 1'b0;
      err_in    = 1'b0;
      if (func_ff == vsos_pkg::FUNC_RESTART) begin
         col_in = '0;
         row_in = '0;
         pix_in = '0;
         if (bad_axis || ({1'b0, cfg.slice} >= extent)) begin
            active_in = 1'b0;
            rsa_in    = '0;
            cur_in    = '0;
            err_in    = 1'b1;
         end else begin
            active_in = 1'b1;
            rsa_in    = start;
            cur_in    = start;
            fetch_in  = start;
         end
      end else if (active_ff) begin
         red_in   = colour[7:0];
         green_in = colour[15:8];
         blue_in  = colour[23:16];
         opix_in  = pix_ff;
         pix_in   = pix_ff + vsos_pkg::PIX_W'(1);
         if (next_col >= width) begin
            if (next_row >= height) begin
               active_in = 1'b0;
               col_in    = '0;
               row_in    = '0;
               last_in   = 1'b1;
            end else begin
               col_in   = '0;
               row_in   = next_row[vsos_pkg::CNT_W-1:0];
               rsa_in   = row_next;
               cur_in   = row_next;
               fetch_in = row_next;
            end
         end else begin
            col_in   = next_col[vsos_pkg::CNT_W-1:0];
            cur_in   = cur_ff + col_stride;
            fetch_in = cur_ff + col_stride;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         rsa_ff    <= '0;
         cur_ff    <= '0;
         pix_ff    <= '0;
         active_ff <= 1'b0;
      end else if (cmd.commit) begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         rsa_ff    <= rsa_in;
         cur_ff    <= cur_in;
         pix_ff    <= pix_in;
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         opix_ff  <= opix_in;
         fetch_ff <= fetch_in;
         last_ff  <= last_in;
         err_ff   <= err_in;
      end
   end

   assign out_red   = red_ff;
   assign out_green = green_ff;
   assign out_blue  = blue_ff;
   assign out_pixel = opix_ff;
   assign out_fetch = fetch_ff;
   assign out_last  = last_ff;
   assign out_error = err_ff;

endmodule
